FILE: hdl/ptlru_pkg.sv
// shared constants, field types and inter-module structs for the page table
// with fifo / lru frame replacement; no dependencies
package ptlru_pkg;

    localparam int PAGES     = 64;
    localparam int FRAMES    = 8;
    localparam int DATA_BITS = 32;

    localparam int PAGE_W  = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int STAMP_W = 32;
    localparam int FAULT_W = 16;

    localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

    localparam logic MODE_FIFO = 1'b0;
    localparam logic MODE_LRU  = 1'b1;

    typedef logic [PAGE_W-1:0]    t_page;
    typedef logic [FRAME_W-1:0]   t_frame;
    typedef logic [STAMP_W-1:0]   t_stamp;
    typedef logic [DATA_BITS-1:0] t_word;
    typedef logic [FAULT_W-1:0]   t_fault;

    typedef struct packed {
        t_page page_number;
        t_word item_data;
    } t_in;

    typedef struct packed {
        logic   hit;
        t_frame frame_index;
        t_word  frame_data;
        logic   evicted;
        t_page  evicted_page;
        t_fault fault_count;
    } t_out;

    // one frame table entry
    typedef struct packed {
        t_page owner;
        t_word word;
    } t_frame_ent;

    // victim scan unit towards the controller
    typedef struct packed {
        logic   rd_en;
        t_frame rd_addr;
        logic   done;
        t_frame best;
    } t_scan_st;

endpackage

FILE: hdl/ptlru_ram.sv
// generic single-clock ram, one write port and one read port with registered read
// no dependencies
module ptlru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/ptlru_victim.sv
// victim search: walks the stamp memory one frame a cycle and keeps the oldest
// depends on ptlru_pkg
module ptlru_victim import ptlru_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_stamp   i_clock,
    input  t_stamp   i_stamp,
    output t_scan_st o_st
);

    localparam int CNT_W = $clog2(FRAMES + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_pend;
    t_frame           r_pidx;
    t_frame           r_best;
    t_stamp           r_best_age;
    logic             r_done;

    logic   rd_en;
    logic   last;
    t_stamp age;

    assign rd_en = r_busy && (r_cnt < CNT_W'(FRAMES));
    assign last  = r_pend && (r_pidx == FRAME_W'(FRAMES - 1));
    // wrap-safe age against the running stamp clock
    assign age   = i_clock - i_stamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pend <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= last;
            r_pend <= rd_en;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else begin
                if (rd_en) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= r_cnt[FRAME_W-1:0];
        // ties keep the lower index
        if (r_pend && ((r_pidx == '0) || (age > r_best_age))) begin
            r_best     <= r_pidx;
            r_best_age <= age;
        end
    end

    assign o_st.rd_en   = rd_en;
    assign o_st.rd_addr = r_cnt[FRAME_W-1:0];
    assign o_st.done    = r_done;
    assign o_st.best    = r_best;

endmodule

FILE: hdl/page_table_with_lru_fifo_replacement.sv
// Page table with fifo or lru frame replacement. One reference is taken at a time.
// A hit, or a fault that finds a free frame, passes from the input transfer through
// the lookup state to the hit or fill state, which writes the result into the
// output register once it is free and then reopens the input. A fault with every
// frame in use runs the victim search, which reads one stamp per cycle from the
// stamp memory, and then goes through the evict and fill states. A finished result
// waits in the output register while the next reference is already being looked up.
// Uses ptlru_pkg, ptlru_ram and ptlru_victim.
module page_table_with_lru_fifo_replacement import ptlru_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_data,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOOK  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_EVICT = 3'd3;
    localparam logic [2:0] S_FILL  = 3'd4;
    localparam logic [2:0] S_HIT   = 3'd5;

    logic [2:0]       r_state, n_state;
    logic             r_mode;
    logic [PAGES-1:0] r_page_valid;
    logic [FRAMES-1:0] r_used;
    t_stamp           r_clock;
    t_fault           r_faults;
    t_page            r_page;
    t_word            r_data;
    t_frame           r_frame;
    logic             r_evict;
    t_page            r_evict_page;
    logic             r_out_valid;
    t_out             r_out;

    logic       accept;
    logic       out_free;
    logic       free_any;
    t_frame     free_idx;
    t_fault     faults_inc;
    t_frame     pt_rdata;
    t_frame_ent fr_rdata;
    t_frame_ent fr_wdata;
    logic       fr_re;
    t_frame     fr_raddr;
    t_stamp     st_rdata;
    logic       st_we;
    logic       fill_go;
    logic       hit_go;
    logic       scan_start;
    t_scan_st   scan;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fill_go    = (r_state == S_FILL) && out_free;
    assign hit_go     = (r_state == S_HIT) && out_free;
    assign st_we      = fill_go || (hit_go && (r_mode == MODE_LRU));
    assign faults_inc = (r_faults == FAULT_MAX) ? r_faults : r_faults + 1'b1;
    assign scan_start = (r_state == S_LOOK) && !r_page_valid[r_page] && !free_any;

    // lowest free frame
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int k = FRAMES - 1; k >= 0; k--) begin
            if (!r_used[k]) begin
                free_any = 1'b1;
                free_idx = FRAME_W'(k);
            end
        end
    end

    always_comb begin
        fr_re    = 1'b0;
        fr_raddr = scan.best;
        if ((r_state == S_LOOK) && r_page_valid[r_page]) begin
            fr_re    = 1'b1;
            fr_raddr = pt_rdata;
        end else if ((r_state == S_SCAN) && scan.done) begin
            fr_re = 1'b1;
        end
    end

    assign fr_wdata.owner = r_page;
    assign fr_wdata.word  = r_data;

    ptlru_ram #(.WIDTH(FRAME_W), .DEPTH(PAGES)) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (fill_go),
        .i_waddr (r_page),
        .i_wdata (r_frame),
        .i_re    (accept),
        .i_raddr (i_in_data.page_number),
        .o_rdata (pt_rdata)
    );

    ptlru_ram #(.WIDTH($bits(t_frame_ent)), .DEPTH(FRAMES)) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (fill_go),
        .i_waddr (r_frame),
        .i_wdata (fr_wdata),
        .i_re    (fr_re),
        .i_raddr (fr_raddr),
        .o_rdata (fr_rdata)
    );

    ptlru_ram #(.WIDTH(STAMP_W), .DEPTH(FRAMES)) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (r_frame),
        .i_wdata (r_clock),
        .i_re    (scan.rd_en),
        .i_raddr (scan.rd_addr),
        .o_rdata (st_rdata)
    );

    ptlru_victim u_victim (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (scan_start),
        .i_clock (r_clock),
        .i_stamp (st_rdata),
        .o_st    (scan)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept) n_state = S_LOOK;
            S_LOOK: begin
                if (r_page_valid[r_page]) begin
                    n_state = S_HIT;
                end else if (free_any) begin
                    n_state = S_FILL;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN:  if (scan.done) n_state = S_EVICT;
            S_EVICT: n_state = S_FILL;
            S_FILL:  if (out_free) n_state = S_IDLE;
            S_HIT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mode       <= MODE_LRU;
            r_page_valid <= '0;
            r_used       <= '0;
            r_clock      <= '0;
            r_faults     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            // the evicted page is never the one being filled
            if (r_state == S_EVICT) begin
                r_page_valid[fr_rdata.owner] <= 1'b0;
            end
            if (fill_go) begin
                r_page_valid[r_page] <= 1'b1;
                r_used[r_frame]      <= 1'b1;
                r_faults             <= faults_inc;
            end
            if (st_we) begin
                r_clock <= r_clock + 1'b1;
            end
            if (fill_go || hit_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_page <= i_in_data.page_number;
            r_data <= i_in_data.item_data;
        end
        if (r_state == S_LOOK) begin
            r_evict <= 1'b0;
            if (r_page_valid[r_page]) begin
                r_frame <= pt_rdata;
            end else begin
                r_frame <= free_idx;
            end
        end
        if ((r_state == S_SCAN) && scan.done) begin
            r_frame <= scan.best;
            r_evict <= 1'b1;
        end
        if (r_state == S_EVICT) begin
            r_evict_page <= fr_rdata.owner;
        end
        if (fill_go) begin
            r_out.hit          <= 1'b0;
            r_out.frame_index  <= r_frame;
            r_out.frame_data   <= r_data;
            r_out.evicted      <= r_evict;
            r_out.evicted_page <= r_evict ? r_evict_page : '0;
            r_out.fault_count  <= faults_inc;
        end else if (hit_go) begin
            r_out.hit          <= 1'b1;
            r_out.frame_index  <= r_frame;
            r_out.frame_data   <= fr_rdata.word;
            r_out.evicted      <= 1'b0;
            r_out.evicted_page <= '0;
            r_out.fault_count  <= r_faults;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // one reference at a time: a transfer in closes the input until it is done
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while a reference is in flight");

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.hit && o_out_data.evicted))
        else $error("hit reported together with an eviction");

    // eviction only once every frame is in use
    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.evicted) |-> (&r_used))
        else $error("eviction while a frame was still free");

    // the search only starts when nothing is free
    a_scan_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_start |-> (&r_used))
        else $error("victim search started with a free frame");

endmodule
